@@ rtl/core/xsr256_pkg.sv @@
// Package with the transaction types, constants and datapath commands of the xoshiro256** generator.
package xsr256_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int NUM_WORDS = 4;
    localparam int IDX_W     = 2;
    localparam int FRAC_W    = 53;

    // Command codes carried in the input transaction.
    localparam logic CMD_NEXT = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    // splitmix64 constants.
    localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d049bb133111eb;

    // Multiplier constant select.
    localparam logic K_SEL_MUL1 = 1'b0;
    localparam logic K_SEL_MUL2 = 1'b1;

    // Datapath operation codes.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE         = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SEED    = 4'd1;
    localparam logic [OP_W-1:0] OP_CTR_STEP     = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_LO       = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_CROSS_HI = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_CROSS_LO = 4'd5;
    localparam logic [OP_W-1:0] OP_MIX_MID      = 4'd6;
    localparam logic [OP_W-1:0] OP_STORE_WORD   = 4'd7;
    localparam logic [OP_W-1:0] OP_NEXT_PRE     = 4'd8;
    localparam logic [OP_W-1:0] OP_NEXT_OUT     = 4'd9;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] seed_value;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] random_word;
        logic [FRAC_W-1:0] unit_fraction;
    } t_out_item;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             k_sel;
        logic [IDX_W-1:0] word_idx;
    } t_dp_cmd;

endpackage

@@ rtl/core/xsr256_ctrl.sv @@
// Controller state machine that sequences seeding, next-value generation and the output register.
module xsr256_ctrl
    import xsr256_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_cmd,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_dp_cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] S_CTR    = 4'd1;
    localparam logic [ST_W-1:0] S_M1A    = 4'd2;
    localparam logic [ST_W-1:0] S_M1B    = 4'd3;
    localparam logic [ST_W-1:0] S_M1C    = 4'd4;
    localparam logic [ST_W-1:0] S_MID    = 4'd5;
    localparam logic [ST_W-1:0] S_M2A    = 4'd6;
    localparam logic [ST_W-1:0] S_M2B    = 4'd7;
    localparam logic [ST_W-1:0] S_M2C    = 4'd8;
    localparam logic [ST_W-1:0] S_STORE  = 4'd9;
    localparam logic [ST_W-1:0] S_NEXT_A = 4'd10;
    localparam logic [ST_W-1:0] S_NEXT_B = 4'd11;

    logic [ST_W-1:0]  r_state, n_state;
    logic [IDX_W-1:0] r_word_idx, n_word_idx;
    logic             r_out_valid, n_out_valid;
    logic             in_accept;
    logic             out_free;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state         = r_state;
        n_word_idx      = r_word_idx;
        n_out_valid     = r_out_valid && i_out_stall;
        o_dp_cmd.op       = OP_NONE;
        o_dp_cmd.k_sel    = K_SEL_MUL1;
        o_dp_cmd.word_idx = r_word_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_cmd == CMD_SEED) begin
                        o_dp_cmd.op = OP_LOAD_SEED;
                        n_word_idx  = '0;
                        n_state     = S_CTR;
                    end else begin
                        n_state = S_NEXT_A;
                    end
                end
            end
            S_CTR: begin
                o_dp_cmd.op = OP_CTR_STEP;
                n_state     = S_M1A;
            end
            S_M1A: begin
                o_dp_cmd.op = OP_MUL_LO;
                n_state     = S_M1B;
            end
            S_M1B: begin
                o_dp_cmd.op = OP_MUL_CROSS_HI;
                n_state     = S_M1C;
            end
            S_M1C: begin
                o_dp_cmd.op = OP_MUL_CROSS_LO;
                n_state     = S_MID;
            end
            S_MID: begin
                o_dp_cmd.op = OP_MIX_MID;
                n_state     = S_M2A;
            end
            S_M2A: begin
                o_dp_cmd.op    = OP_MUL_LO;
                o_dp_cmd.k_sel = K_SEL_MUL2;
                n_state        = S_M2B;
            end
            S_M2B: begin
                o_dp_cmd.op    = OP_MUL_CROSS_HI;
                o_dp_cmd.k_sel = K_SEL_MUL2;
                n_state        = S_M2C;
            end
            S_M2C: begin
                o_dp_cmd.op    = OP_MUL_CROSS_LO;
                o_dp_cmd.k_sel = K_SEL_MUL2;
                n_state        = S_STORE;
            end
            S_STORE: begin
                o_dp_cmd.op = OP_STORE_WORD;
                if (r_word_idx == IDX_W'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_word_idx = r_word_idx + 1'b1;
                    n_state    = S_CTR;
                end
            end
            S_NEXT_A: begin
                o_dp_cmd.op = OP_NEXT_PRE;
                n_state     = S_NEXT_B;
            end
            S_NEXT_B: begin
                if (out_free) begin
                    o_dp_cmd.op = OP_NEXT_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_word_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word_idx  <= n_word_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_next_enters_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_cmd == CMD_NEXT)) |=> (r_state == S_NEXT_A))
        else $error("next transaction did not start generation");

    a_seed_starts_word0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_cmd == CMD_SEED)) |=> ((r_state == S_CTR) && (r_word_idx == '0)))
        else $error("seed transaction did not start at word zero");

    a_last_store_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STORE) && (r_word_idx == IDX_W'(NUM_WORDS - 1))) |=> (r_state == S_IDLE))
        else $error("seeding did not finish after the last word");

    a_result_from_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_NEXT_B))
        else $error("result appeared without a next transaction");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dp_cmd.op == OP_NEXT_OUT) |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while held");

endmodule

@@ rtl/core/xsr256_datapath.sv @@
// Datapath with the generator state, the splitmix64 mixer, a shared 32x32 multiplier and the result register.
module xsr256_datapath
    import xsr256_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_dp_cmd,
    input  logic [WORD_W-1:0] i_seed_value,
    output t_out_item         o_result
);

    logic [WORD_W-1:0] r_gen_words [NUM_WORDS];
    logic [WORD_W-1:0] n_gen_words [NUM_WORDS];
    logic [WORD_W-1:0] r_ctr, n_ctr;
    logic [WORD_W-1:0] r_z, n_z;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_pre, n_pre;
    t_out_item         r_result, n_result;

    logic [WORD_W-1:0] ctr_sum;
    logic [WORD_W-1:0] k_val;
    logic [HALF_W-1:0] mul_a, mul_b;
    logic [WORD_W-1:0] prod;
    logic [WORD_W-1:0] upd_t, upd_w2, upd_w3;
    logic [WORD_W-1:0] rot_pre, out_word;

    assign ctr_sum = r_ctr + SM_GAMMA;
    assign k_val   = (i_dp_cmd.k_sel == K_SEL_MUL2) ? SM_MUL2 : SM_MUL1;

    // Low 64 bits of z*k from three 32x32 partial products, one per cycle.
    always_comb begin
        mul_a = r_z[HALF_W-1:0];
        mul_b = k_val[HALF_W-1:0];
        if (i_dp_cmd.op == OP_MUL_CROSS_HI) begin
            mul_a = r_z[WORD_W-1:HALF_W];
        end
        if (i_dp_cmd.op == OP_MUL_CROSS_LO) begin
            mul_b = k_val[WORD_W-1:HALF_W];
        end
    end

    assign prod = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

    // xoshiro256 update terms.
    assign upd_t  = {r_gen_words[1][WORD_W-18:0], 17'd0};
    assign upd_w2 = r_gen_words[2] ^ r_gen_words[0];
    assign upd_w3 = r_gen_words[3] ^ r_gen_words[1];

    assign rot_pre  = {r_pre[WORD_W-8:0], r_pre[WORD_W-1:WORD_W-7]};
    assign out_word = rot_pre + {rot_pre[WORD_W-4:0], 3'd0};

    always_comb begin
        n_gen_words = r_gen_words;
        n_ctr       = r_ctr;
        n_z         = r_z;
        n_acc       = r_acc;
        n_pre       = r_pre;
        n_result    = r_result;
        unique case (i_dp_cmd.op)
            OP_NONE: begin
            end
            OP_LOAD_SEED: begin
                n_ctr = i_seed_value;
            end
            OP_CTR_STEP: begin
                n_ctr = ctr_sum;
                n_z   = ctr_sum ^ (ctr_sum >> 30);
            end
            OP_MUL_LO: begin
                n_acc = prod;
            end
            OP_MUL_CROSS_HI, OP_MUL_CROSS_LO: begin
                n_acc[WORD_W-1:HALF_W] = r_acc[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
            end
            OP_MIX_MID: begin
                n_z = r_acc ^ (r_acc >> 27);
            end
            OP_STORE_WORD: begin
                n_gen_words[i_dp_cmd.word_idx] = r_acc ^ (r_acc >> 31);
            end
            OP_NEXT_PRE: begin
                n_pre          = r_gen_words[1] + {r_gen_words[1][WORD_W-3:0], 2'd0};
                n_gen_words[0] = r_gen_words[0] ^ upd_w3;
                n_gen_words[1] = r_gen_words[1] ^ upd_w2;
                n_gen_words[2] = upd_w2 ^ upd_t;
                n_gen_words[3] = {upd_w3[WORD_W-46:0], upd_w3[WORD_W-1:WORD_W-45]};
            end
            OP_NEXT_OUT: begin
                n_result.random_word   = out_word;
                n_result.unit_fraction = out_word[WORD_W-1:WORD_W-FRAC_W];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_gen_words[i] <= '0;
            end
        end else begin
            r_gen_words <= n_gen_words;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctr    <= n_ctr;
        r_z      <= n_z;
        r_acc    <= n_acc;
        r_pre    <= n_pre;
        r_result <= n_result;
    end

    assign o_result = r_result;

endmodule

@@ rtl/core/xoshiro256ss_generator.sv @@
// Top level of the xoshiro256** generator with splitmix64 seeding.
//
// Input channel: i_in_valid / o_in_stall / i_in_data. A transaction carries a
// command bit and a 64-bit seed. A next command (cmd 0) yields one output
// transaction; a seed command (cmd 1) reloads the 256-bit state from four
// successive splitmix64 outputs and yields nothing.
// Output channel: o_out_valid / i_out_stall / o_out_data with the 64-bit word
// and its top 53 bits as a fraction scaled by 2^-53.
// One command is in work at a time. A next command passes a pre step
// (state update and the product by five) and an output step, and the
// block takes a new command once the result is registered. A seed
// command holds the input stalled until the last state word is stored:
// per state word one counter step, two 64-bit products on the shared
// 32x32 multiplier, each summed from partial products, one mixing step
// and one store.
// The output register decouples the channels: a held result does not block a
// seed command, and a following next command waits in its final step until
// the receiver takes the held transaction.
// Reset (synchronous, active low) clears the state words to zero, so next
// commands return zero until the first seed command.
module xoshiro256ss_generator
    import xsr256_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd dp_cmd;

    // Sequencer: accepts transactions and drives the datapath step by step.
    xsr256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_data.cmd),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_dp_cmd    (dp_cmd)
    );

    // State words, mixer, shared multiplier and the result register.
    xsr256_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp_cmd     (dp_cmd),
        .i_seed_value (i_in_data.seed_value),
        .o_result     (o_out_data)
    );

endmodule

@@ bench/xoshiro256ss_generator_tb.sv @@
// Self-checking testbench for the xoshiro256** generator with splitmix64 seeding.
module xoshiro256ss_generator_tb;
    import xsr256_pkg::*;

    // Own copies of the splitmix64 and xoshiro256** constants for the predictor,
    // so that a wrong constant in the design package cannot hide itself.
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
    localparam int          XOR_SHIFT    = 17;
    localparam int          STATE_ROT    = 45;

    // Items per random phase; three phases give about 1500 commands.
    localparam int PHASE_ITEMS    = 500;
    // Cycles with no transaction on either channel before the run is abandoned.
    // A seed command stalls the input through all its steps and a stalled result waits on the
    // receiver, so this leaves a wide margin over the slowest correct run.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles to watch the output after the last expected result has arrived.
    localparam int TAIL_CYCLES    = 50;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // Percentages of cycles in which the sender holds back and the
    // receiver stalls; the test sequence changes them between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Predicted generator state and the results still owed by the design.
    logic [63:0] gen_state [4];
    t_out_item   expected_results [$];

    int unsigned next_count     = 0;
    int unsigned seed_count     = 0;
    int unsigned checked_count  = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    xoshiro256ss_generator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Clock with a period of 8 time units.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] rotl64(input logic [63:0] value, input int amount);
        return (value << amount) | (value >> (64 - amount));
    endfunction

    // The splitmix64 output function applied to the already advanced counter.
    function automatic logic [63:0] splitmix_finalize(input logic [63:0] counter);
        logic [63:0] z;
        z = counter;
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // Applies one accepted command to the predicted state and queues the
    // result that a next command owes.
    task automatic predict_command(input t_in_item item);
        logic [63:0] counter;
        logic [63:0] word;
        logic [63:0] shifted;
        t_out_item   result;
        if (item.cmd == CMD_SEED) begin
            // The counter starts from the seed every time; nothing persists.
            counter = item.seed_value;
            for (int i = 0; i < 4; i++) begin
                counter      = counter + GOLDEN_GAMMA;
                gen_state[i] = splitmix_finalize(counter);
            end
            seed_count++;
        end else begin
            word    = rotl64(gen_state[1] * 64'd5, 7) * 64'd9;
            shifted = gen_state[1] << XOR_SHIFT;
            gen_state[2] = gen_state[2] ^ gen_state[0];
            gen_state[3] = gen_state[3] ^ gen_state[1];
            gen_state[1] = gen_state[1] ^ gen_state[2];
            gen_state[0] = gen_state[0] ^ gen_state[3];
            gen_state[2] = gen_state[2] ^ shifted;
            gen_state[3] = rotl64(gen_state[3], STATE_ROT);
            result.random_word   = word;
            result.unit_fraction = word[63:11];
            expected_results.push_back(result);
            next_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------

    function automatic logic [63:0] random_word64();
        return {$urandom(), $urandom()};
    endfunction

    // Seeds biased toward the extremes of the 64-bit range.
    function automatic logic [63:0] random_seed();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(63);
            default: return random_word64();
        endcase
    endfunction

    // Sends one command transaction. Inputs change only at the falling edge,
    // and valid is either kept high into the next transaction or lowered for
    // a few idle cycles, never both within one time step.
    task automatic send_command(input logic cmd, input logic [63:0] seed);
        t_in_item item;
        item.cmd        = cmd;
        item.seed_value = seed;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        // The payload stays put until the design takes it.
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_command(item);
    endtask

    task automatic send_next();
        // The seed field carries random content; the design must ignore it.
        send_command(CMD_NEXT, random_word64());
    endtask

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------

    // Each output transaction is compared with the oldest prediction. The
    // design updates on nonblocking assignments, so the values seen here
    // are those from just before the edge.
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word %h fraction %h",
                         $time, out_data.random_word, out_data.unit_fraction);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                if (out_data.random_word !== want.random_word) begin
                    $display("%0t: random_word expected %h actual %h",
                             $time, want.random_word, out_data.random_word);
                    mismatch_count++;
                end
                if (out_data.unit_fraction !== want.unit_fraction) begin
                    $display("%0t: unit_fraction expected %h actual %h",
                             $time, want.unit_fraction, out_data.unit_fraction);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when neither channel has moved a transaction for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight after reset the state is all zero, so every next command
    // returns zero and leaves the state zero, whatever the seed field holds.
    task automatic test_zero_state();
        send_command(CMD_NEXT, '0);
        send_command(CMD_NEXT, '1);
        send_next();
    endtask

    // Seeds at the extremes of the range, each followed by one or two next
    // commands so that the loaded words and the first updates are seen.
    task automatic test_seed_extremes();
        send_command(CMD_SEED, '0);
        send_next();
        send_next();
        send_command(CMD_SEED, '1);
        send_next();
        send_next();
        send_command(CMD_SEED, 64'd1);
        send_next();
        send_command(CMD_SEED, 64'h8000_0000_0000_0000);
        send_next();
        send_command(CMD_SEED, 64'h5555_5555_5555_5555);
        send_next();
    endtask

    // The seed field is ignored on next commands, and reseeding with the same
    // value restarts the same sequence: the splitmix counter keeps nothing
    // from an earlier seed command, even when two seeds come back to back.
    task automatic test_reseed_behavior();
        logic [63:0] seed;
        seed = random_word64();
        send_command(CMD_SEED, seed);
        send_command(CMD_NEXT, '0);
        send_command(CMD_NEXT, '1);
        send_command(CMD_SEED, random_word64());
        send_command(CMD_SEED, seed);
        send_command(CMD_NEXT, '1);
        send_command(CMD_NEXT, '0);
    endtask

    // Mostly well-formed streams: a seed followed by a run of next commands.
    // About one step in ten is a lone command of either kind instead, which
    // also produces runs of back-to-back seeds and next commands with no
    // seed in between.
    task automatic test_random_streams(input int unsigned item_budget);
        int unsigned sent;
        int unsigned run_length;
        sent = 0;
        while (sent < item_budget) begin
            if ($urandom_range(9) == 0) begin
                send_command(1'($urandom_range(1)), random_seed());
                sent++;
            end else begin
                send_command(CMD_SEED, random_seed());
                run_length = $urandom_range(1, 40);
                repeat (run_length)
                    send_next();
                sent += run_length + 1;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 4; i++)
            gen_state[i] = '0;

        // Synchronous reset, released at a falling edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // First profile: sender idles now and then, receiver stalls often.
        send_idle_pct = 16;
        recv_idle_pct = 45;
        test_zero_state();
        test_seed_extremes();
        test_reseed_behavior();
        test_random_streams(PHASE_ITEMS);

        // Second profile: the other way round.
        send_idle_pct = 45;
        recv_idle_pct = 16;
        test_random_streams(PHASE_ITEMS);

        // Third profile: full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_streams(PHASE_ITEMS);

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain: the watchdog bounds this wait if a result never shows up.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d next and %0d seed commands under three flow-control profiles.",
                 next_count, seed_count);
        $display("Compared %0d results, found %0d mismatching fields.",
                 checked_count, mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
